/* sv/ptc_pkg.sv */
package ptc_pkg;

  // Field and port widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int PRES_W    = 19;
  localparam int TOUT_W    = 15;

  // Internal datapath widths
  localparam int DT_W      = RAW_W + 1;
  localparam int PROD1_W   = DT_W + COEF_W + 1;
  localparam int TRAW_W    = 19;
  localparam int OFFR_W    = 35;
  localparam int SENSR_W   = 34;
  localparam int DTSQ_W    = 48;
  localparam int TI_W      = 17;
  localparam int OFF_W     = 36;
  localparam int SENS_W    = 35;
  localparam int SD_W      = 66;

  // Scaling shifts (powers of two of the compensation formulae)
  localparam int SH_TEMP      = 23;
  localparam int SH_OFF       = 7;
  localparam int SH_SENS      = 8;
  localparam int SH_OFF_BASE  = 16;
  localparam int SH_SENS_BASE = 15;
  localparam int SH_REF       = 8;
  localparam int SH_TI_LOW    = 33;
  localparam int SH_TI_HIGH   = 36;
  localparam int SH_P1        = 21;
  localparam int SH_P2        = 13;

  // Temperature bands and output limits
  localparam int TEMP_BASE  = 2000;
  localparam int VLOW_OFS   = 3500;
  localparam int VLOW_LIMIT = -3500;
  localparam int P_MAX      = 300000;
  localparam int T_MIN      = -4000;
  localparam int T_MAX      = 8500;

  // Queues and pipelines
  localparam int MQ_DEPTH     = 4;
  localparam int MQ_PTR_W     = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH     = 2;
  localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 9;

  typedef enum logic [2:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    BAND_HIGH = 2'd0,
    BAND_LOW  = 2'd1,
    BAND_VLOW = 2'd2
  } band_e;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_temp;
    logic [COEF_W-1:0] offset_temp;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_slope;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0]          d1;
    logic signed [TRAW_W-1:0]  dtemp;
    logic signed [OFFR_W-1:0]  off_raw;
    logic signed [SENSR_W-1:0] sens_raw;
    logic [TI_W-1:0]           ti;
    band_e                     band;
  } mid_t;

  typedef struct packed {
    logic [PRES_W-1:0]        pressure;
    logic signed [TOUT_W-1:0] temperature;
    logic                     clipped;
  } out_t;

  // Signed divide by 2^k, truncating toward zero
  function automatic logic signed [SD_W-1:0] sdiv2(input logic signed [SD_W-1:0] v,
                                                   input int unsigned k);
    logic signed [SD_W-1:0] bias;
    bias = v[SD_W-1] ? ((SD_W'(1) << k) - SD_W'(1)) : '0;
    return (v + bias) >>> k;
  endfunction

endpackage

/* sv/ptc_cfg.sv */
module ptc_cfg
  import ptc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output logic               pready_o,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx      = reg_idx_e'(paddr_i[PADDR_W-1:2]);
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SENS:        cfg_d.sens        = pwdata_i[COEF_W-1:0];
        REG_OFFSET:      cfg_d.offset      = pwdata_i[COEF_W-1:0];
        REG_SENS_TEMP:   cfg_d.sens_temp   = pwdata_i[COEF_W-1:0];
        REG_OFFSET_TEMP: cfg_d.offset_temp = pwdata_i[COEF_W-1:0];
        REG_REF_TEMP:    cfg_d.ref_temp    = pwdata_i[COEF_W-1:0];
        REG_TEMP_SLOPE:  cfg_d.temp_slope  = pwdata_i[COEF_W-1:0];
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENS:        prdata_o = PDATA_W'(cfg_q.sens);
      REG_OFFSET:      prdata_o = PDATA_W'(cfg_q.offset);
      REG_SENS_TEMP:   prdata_o = PDATA_W'(cfg_q.sens_temp);
      REG_OFFSET_TEMP: prdata_o = PDATA_W'(cfg_q.offset_temp);
      REG_REF_TEMP:    prdata_o = PDATA_W'(cfg_q.ref_temp);
      REG_TEMP_SLOPE:  prdata_o = PDATA_W'(cfg_q.temp_slope);
      default:         prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* sv/ptc_front.sv */
module ptc_front
  import ptc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [RAW_W-1:0] raw_pressure_i,
  input  logic [RAW_W-1:0] raw_temperature_i,
  output logic             in_ready_o,
  output logic             item_valid_o,
  output mid_t             item_o,
  input  logic             item_ready_i
);

  logic [FRONT_STAGES-1:0] v_q;
  logic                    adv;

  // Stage A: temperature difference
  logic [RAW_W-1:0]        d1_a_q;
  logic signed [DT_W-1:0]  dt_a_q, dt_a_d;

  // Stage B: first-order products and dT squared
  logic [RAW_W-1:0]          d1_b_q;
  logic signed [PROD1_W-1:0] pt_b_q, pt_b_d;
  logic signed [PROD1_W-1:0] po_b_q, po_b_d;
  logic signed [PROD1_W-1:0] ps_b_q, ps_b_d;
  logic signed [2*DT_W-1:0]  sq_full;
  logic [DTSQ_W-1:0]         dtsq_b_q;

  // Stage C: scaled terms and band
  mid_t                      item_c_q, item_c_d;
  logic signed [TRAW_W-1:0]  traw;
  logic [DTSQ_W+1:0]         dtsq3;

  assign adv          = ~v_q[FRONT_STAGES-1] | item_ready_i;
  assign in_ready_o   = adv;
  assign item_valid_o = v_q[FRONT_STAGES-1];
  assign item_o       = item_c_q;

  always_comb begin
    dt_a_d = $signed({1'b0, raw_temperature_i})
           - $signed({1'b0, cfg_i.ref_temp, {SH_REF{1'b0}}});
  end

  always_comb begin
    pt_b_d  = PROD1_W'(dt_a_q) * PROD1_W'($signed({1'b0, cfg_i.temp_slope}));
    po_b_d  = PROD1_W'(dt_a_q) * PROD1_W'($signed({1'b0, cfg_i.offset_temp}));
    ps_b_d  = PROD1_W'(dt_a_q) * PROD1_W'($signed({1'b0, cfg_i.sens_temp}));
    sq_full = dt_a_q * dt_a_q;
  end

  always_comb begin
    traw  = TRAW_W'(sdiv2(SD_W'(pt_b_q), SH_TEMP));
    dtsq3 = {2'b00, dtsq_b_q} + {1'b0, dtsq_b_q, 1'b0};
    item_c_d.d1       = d1_b_q;
    item_c_d.dtemp    = traw;
    item_c_d.off_raw  = OFFR_W'(sdiv2(SD_W'(po_b_q), SH_OFF));
    item_c_d.sens_raw = SENSR_W'(sdiv2(SD_W'(ps_b_q), SH_SENS));
    // classify on the first-order temperature relative to 20 degC
    if (traw < $signed(TRAW_W'(VLOW_LIMIT))) begin
      item_c_d.band = BAND_VLOW;
      item_c_d.ti   = dtsq3[DTSQ_W+1:SH_TI_LOW];
    end else if (traw < $signed(TRAW_W'(0))) begin
      item_c_d.band = BAND_LOW;
      item_c_d.ti   = dtsq3[DTSQ_W+1:SH_TI_LOW];
    end else begin
      item_c_d.band = BAND_HIGH;
      item_c_d.ti   = TI_W'(dtsq_b_q[DTSQ_W-1:SH_TI_HIGH]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_a_q   <= raw_pressure_i;
      dt_a_q   <= dt_a_d;
      d1_b_q   <= d1_a_q;
      pt_b_q   <= pt_b_d;
      po_b_q   <= po_b_d;
      ps_b_q   <= ps_b_d;
      dtsq_b_q <= sq_full[DTSQ_W-1:0];
      item_c_q <= item_c_d;
    end
  end

endmodule

/* sv/ptc_queue.sv */
module ptc_queue
  import ptc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  mid_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output mid_t data_o
);

  mid_t                mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [MQ_PTR_W:0]   cnt_q, cnt_d;
  logic                wr_en, rd_en;

  assign full_o  = (cnt_q == (MQ_PTR_W+1)'(MQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i & ~full_o;
  assign rd_en   = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/ptc_back.sv */
module ptc_back
  import ptc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     item_valid_i,
  input  mid_t                     item_i,
  output logic                     item_ready_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [PRES_W-1:0]        pressure_out_o,
  output logic signed [TOUT_W-1:0] temperature_out_o,
  output logic                     clipped_o
);

  localparam int DQ_W    = 34;
  localparam int E_W     = TRAW_W + 1;
  localparam int EQ_W    = 36;
  localparam int T_W     = E_W + 1;
  localparam int O1_W    = 35;
  localparam int S1_W    = 34;
  localparam int OFFI_W  = 40;
  localparam int SENSI_W = 39;
  localparam int OFFC_W  = 42;
  localparam int SENSC_W = 41;
  localparam int LO_W    = 20;
  localparam int HI_W    = SENSC_W - LO_W;
  localparam int MLO_W   = RAW_W + LO_W;
  localparam int MHI_W   = RAW_W + 1 + HI_W;
  localparam int Q1_W    = 45;
  localparam int V_W     = 46;
  localparam int P_W     = 33;

  logic [BACK_STAGES-1:0] v_q;
  logic                   adv;

  // Stage A
  logic [RAW_W-1:0]          d1_a_q;
  logic [DQ_W-1:0]           dq_a_q;
  logic signed [2*TRAW_W-1:0] dq_full;
  logic signed [E_W-1:0]     e_a_q, e_a_d;
  logic signed [E_W-1:0]     temp_a_q, temp_a_d;
  logic signed [OFF_W-1:0]   off_a_q, off_a_d;
  logic signed [SENS_W-1:0]  sens_a_q, sens_a_d;
  logic [TI_W-1:0]           ti_a_q;
  band_e                     band_a_q;

  // Stage B
  logic [RAW_W-1:0]          d1_b_q;
  logic signed [2*E_W-1:0]   eq_full;
  logic [EQ_W-1:0]           eq_b_q;
  logic [O1_W-1:0]           o1_b_q, o1_b_d;
  logic [S1_W-1:0]           s1_b_q, s1_b_d;
  logic signed [T_W-1:0]     t_b_q, t_b_d;
  logic signed [OFF_W-1:0]   off_b_q;
  logic signed [SENS_W-1:0]  sens_b_q;
  band_e                     band_b_q;
  logic [DQ_W+1:0]           dq3;
  logic [DQ_W+2:0]           dq5;

  // Stage C
  logic [RAW_W-1:0]          d1_c_q;
  logic [OFFI_W-1:0]         offi_c_q, offi_c_d;
  logic [SENSI_W-1:0]        sensi_c_q, sensi_c_d;
  logic [EQ_W-1:0]           eq_sel;
  logic signed [T_W-1:0]     t_c_q;
  logic signed [OFF_W-1:0]   off_c_q;
  logic signed [SENS_W-1:0]  sens_c_q;

  // Stage D
  logic [RAW_W-1:0]          d1_d_q;
  logic signed [OFFC_W-1:0]  offc_d_q, offc_d_d;
  logic signed [SENSC_W-1:0] sensc_d_q, sensc_d_d;
  logic signed [T_W-1:0]     t_d_q;

  // Stage E
  logic [MLO_W-1:0]          mlo_e_q, mlo_e_d;
  logic signed [MHI_W-1:0]   mhi_e_q, mhi_e_d;
  logic signed [OFFC_W-1:0]  offc_e_q;
  logic signed [T_W-1:0]     t_e_q;

  // Stage F
  logic signed [SD_W-1:0]    prod_f_q, prod_f_d;
  logic signed [OFFC_W-1:0]  offc_f_q;
  logic signed [T_W-1:0]     t_f_q;

  // Stage G
  logic signed [Q1_W-1:0]    q1_g_q, q1_g_d;
  logic signed [OFFC_W-1:0]  offc_g_q;
  logic signed [T_W-1:0]     t_g_q;

  // Stage H
  logic signed [V_W-1:0]     v_h_q, v_h_d;
  logic signed [T_W-1:0]     t_h_q;

  // Stage I
  logic signed [P_W-1:0]     p_i_q, p_i_d;
  logic signed [T_W-1:0]     t_i_q;

  // Result queue
  out_t                      res;
  out_t                      oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]       oq_wr_q, oq_rd_q;
  logic [OQ_PTR_W:0]         oq_cnt_q, oq_cnt_d;
  logic                      oq_full, oq_wr, oq_rd;

  assign oq_full      = (oq_cnt_q == (OQ_PTR_W+1)'(OQ_DEPTH));
  assign adv          = ~(v_q[BACK_STAGES-1] & oq_full);
  assign item_ready_o = adv;

  always_comb begin
    dq_full  = item_i.dtemp * item_i.dtemp;
    e_a_d    = E_W'(item_i.dtemp) + E_W'(VLOW_OFS);
    temp_a_d = E_W'(item_i.dtemp) + E_W'(TEMP_BASE);
    off_a_d  = $signed({4'b0000, cfg_i.offset, {SH_OFF_BASE{1'b0}}})
             + OFF_W'(item_i.off_raw);
    sens_a_d = $signed({4'b0000, cfg_i.sens, {SH_SENS_BASE{1'b0}}})
             + SENS_W'(item_i.sens_raw);
  end

  always_comb begin
    eq_full = e_a_q * e_a_q;
    dq3     = {2'b00, dq_a_q} + {1'b0, dq_a_q, 1'b0};
    dq5     = {3'b000, dq_a_q} + {1'b0, dq_a_q, 2'b00};
    t_b_d   = T_W'(temp_a_q) - $signed({{(T_W-TI_W){1'b0}}, ti_a_q});
    if (band_a_q == BAND_HIGH) begin
      o1_b_d = O1_W'(dq_a_q[DQ_W-1:4]);
      s1_b_d = '0;
    end else begin
      o1_b_d = dq3[DQ_W+1:1];
      s1_b_d = dq5[DQ_W+2:3];
    end
  end

  always_comb begin
    eq_sel    = (band_b_q == BAND_VLOW) ? eq_b_q : '0;
    // very low band adds 7*e^2 to the offset and 4*e^2 to the sensitivity term
    offi_c_d  = OFFI_W'(o1_b_q) + (OFFI_W'(eq_sel) << 3) - OFFI_W'(eq_sel);
    sensi_c_d = SENSI_W'(s1_b_q) + (SENSI_W'(eq_sel) << 2);
  end

  always_comb begin
    offc_d_d  = OFFC_W'(off_c_q) - $signed({2'b00, offi_c_q});
    sensc_d_d = SENSC_W'(sens_c_q) - $signed({2'b00, sensi_c_q});
  end

  // D1 * SENS as two partial products on the low and high parts of SENS
  always_comb begin
    mlo_e_d = MLO_W'(d1_d_q) * MLO_W'(sensc_d_q[LO_W-1:0]);
    mhi_e_d = MHI_W'($signed({1'b0, d1_d_q})) * MHI_W'($signed(sensc_d_q[SENSC_W-1:LO_W]));
  end

  always_comb begin
    prod_f_d = (SD_W'(mhi_e_q) <<< LO_W) + {{(SD_W-MLO_W){1'b0}}, mlo_e_q};
    q1_g_d   = Q1_W'(sdiv2(prod_f_q, SH_P1));
    v_h_d    = V_W'(q1_g_q) - V_W'(offc_g_q);
    p_i_d    = P_W'(sdiv2(SD_W'(v_h_q), SH_P2));
  end

  // Saturate into the result item
  always_comb begin
    res.clipped = 1'b0;
    if (p_i_q < $signed(P_W'(0))) begin
      res.pressure = '0;
      res.clipped  = 1'b1;
    end else if (p_i_q > $signed(P_W'(P_MAX))) begin
      res.pressure = PRES_W'(P_MAX);
      res.clipped  = 1'b1;
    end else begin
      res.pressure = p_i_q[PRES_W-1:0];
    end
    if (t_i_q < $signed(T_W'(T_MIN))) begin
      res.temperature = TOUT_W'(T_MIN);
      res.clipped     = 1'b1;
    end else if (t_i_q > $signed(T_W'(T_MAX))) begin
      res.temperature = TOUT_W'(T_MAX);
      res.clipped     = 1'b1;
    end else begin
      res.temperature = t_i_q[TOUT_W-1:0];
    end
  end

  assign oq_wr = v_q[BACK_STAGES-1] & adv;
  assign oq_rd = pop_i & ~empty_o;

  assign empty_o           = (oq_cnt_q == '0);
  assign pressure_out_o    = oq_q[oq_rd_q].pressure;
  assign temperature_out_o = oq_q[oq_rd_q].temperature;
  assign clipped_o         = oq_q[oq_rd_q].clipped;

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_wr && !oq_rd) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (oq_rd && !oq_wr) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (adv) begin
        v_q <= {v_q[BACK_STAGES-2:0], item_valid_i};
      end
      oq_cnt_q <= oq_cnt_d;
      if (oq_wr) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_rd) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_a_q    <= item_i.d1;
      dq_a_q    <= dq_full[DQ_W-1:0];
      e_a_q     <= e_a_d;
      temp_a_q  <= temp_a_d;
      off_a_q   <= off_a_d;
      sens_a_q  <= sens_a_d;
      ti_a_q    <= item_i.ti;
      band_a_q  <= item_i.band;

      d1_b_q    <= d1_a_q;
      eq_b_q    <= eq_full[EQ_W-1:0];
      o1_b_q    <= o1_b_d;
      s1_b_q    <= s1_b_d;
      t_b_q     <= t_b_d;
      off_b_q   <= off_a_q;
      sens_b_q  <= sens_a_q;
      band_b_q  <= band_a_q;

      d1_c_q    <= d1_b_q;
      offi_c_q  <= offi_c_d;
      sensi_c_q <= sensi_c_d;
      t_c_q     <= t_b_q;
      off_c_q   <= off_b_q;
      sens_c_q  <= sens_b_q;

      d1_d_q    <= d1_c_q;
      offc_d_q  <= offc_d_d;
      sensc_d_q <= sensc_d_d;
      t_d_q     <= t_c_q;

      mlo_e_q   <= mlo_e_d;
      mhi_e_q   <= mhi_e_d;
      offc_e_q  <= offc_d_q;
      t_e_q     <= t_d_q;

      prod_f_q  <= prod_f_d;
      offc_f_q  <= offc_e_q;
      t_f_q     <= t_e_q;

      q1_g_q    <= q1_g_d;
      offc_g_q  <= offc_f_q;
      t_g_q     <= t_f_q;

      v_h_q     <= v_h_d;
      t_h_q     <= t_g_q;

      p_i_q     <= p_i_d;
      t_i_q     <= t_h_q;
    end
  end

endmodule

/* sv/pressure_temp_compensation_unit.sv */
// Path: an item passes the 3 front stages, the short queue and the 9 back stages
//   on its way to the result ports; a stall holds it where it is.
// Throughput: one item per cycle when not stalled; each multiply is registered.
// Reset (rst_ni low, asynchronous): empty all stages and queues, clear the six
//   calibration words to zero. No clearing pass; the block takes items straight away.
module pressure_temp_compensation_unit
  import ptc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item input, queue style
  input  logic                     push,
  output logic                     full,
  input  logic [RAW_W-1:0]         raw_pressure_i,
  input  logic [RAW_W-1:0]         raw_temperature_i,
  // result output, queue style
  output logic                     empty,
  input  logic                     pop,
  output logic [PRES_W-1:0]        pressure_out_o,
  output logic signed [TOUT_W-1:0] temperature_out_o,
  output logic                     clipped_o,
  // calibration register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  cfg_t cfg;
  mid_t front_item, back_item;
  logic front_valid, front_ready;
  logic mq_full, mq_empty;
  logic in_ready;
  logic back_ready;

  // Calibration words C1..C6, written by the user only while idle; not enforced
  ptc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Front: dT, first-order products, scaled terms, band classification
  ptc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (push),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .in_ready_o        (in_ready),
    .item_valid_o      (front_valid),
    .item_o            (front_item),
    .item_ready_i      (front_ready)
  );

  // The front stalls only when its last stage holds an item and the queue is full
  assign full        = ~in_ready;
  assign front_ready = ~mq_full;

  // Short queue decoupling the front from the back
  ptc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (mq_full),
    .pop_i   (back_ready),
    .empty_o (mq_empty),
    .data_o  (back_item)
  );

  // Back: second-order correction, pressure product, saturation, result queue
  ptc_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .item_valid_i      (~mq_empty),
    .item_i            (back_item),
    .item_ready_o      (back_ready),
    .empty_o           (empty),
    .pop_i             (pop),
    .pressure_out_o    (pressure_out_o),
    .temperature_out_o (temperature_out_o),
    .clipped_o         (clipped_o)
  );

endmodule

/* test/compensation_checker.sv */
`timescale 1ns / 1ps

module compensation_checker
  import ptc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic                     full_i,
  input  logic [RAW_W-1:0]         raw_pressure_i,
  input  logic [RAW_W-1:0]         raw_temperature_i,
  input  logic                     empty_i,
  input  logic                     pop_i,
  input  logic [PRES_W-1:0]        pressure_out_i,
  input  logic signed [TOUT_W-1:0] temperature_out_i,
  input  logic                     clipped_i,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic [PADDR_W-1:0]       paddr_i,
  input  logic [PDATA_W-1:0]       pwdata_i,
  input  logic [PDATA_W-1:0]       prdata_i,
  input  logic                     pready_i,
  output int                       pending_o,
  output int                       mismatches_o,
  output int                       checked_o,
  output int                       saturated_o
);

  localparam longint LOW_BAND_EDGE  = 2000;
  localparam longint VLOW_BAND_EDGE = -1500;

  cfg_t cal;
  out_t expected_readings[$];
  int   mismatch_cnt  = 0;
  int   checked_cnt   = 0;
  int   saturated_cnt = 0;

  // shift right by k, rounding toward zero for negative values
  function automatic longint trunc_shift(input longint v, input int unsigned k);
    if (v < 0) return -((-v) >>> k);
    return v >>> k;
  endfunction

  function automatic out_t compensate(input logic [RAW_W-1:0] d1_raw,
                                      input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, dtemp, off, sens, ti, offi, sensi, e, p, t;
    out_t   r;
    d1 = longint'({40'd0, d1_raw});
    d2 = longint'({40'd0, d2_raw});
    c1 = longint'({48'd0, cal.sens});
    c2 = longint'({48'd0, cal.offset});
    c3 = longint'({48'd0, cal.sens_temp});
    c4 = longint'({48'd0, cal.offset_temp});
    c5 = longint'({48'd0, cal.ref_temp});
    c6 = longint'({48'd0, cal.temp_slope});

    // first order
    dt   = d2 - c5 * 256;
    temp = LOW_BAND_EDGE + trunc_shift(dt * c6, 23);
    off  = c2 * 65536 + trunc_shift(c4 * dt, 7);
    sens = c1 * 32768 + trunc_shift(c3 * dt, 8);

    // second order, banded on the first-order temperature
    dtemp = temp - LOW_BAND_EDGE;
    if (temp < LOW_BAND_EDGE) begin
      ti    = trunc_shift(3 * dt * dt, 33);
      offi  = (3 * dtemp * dtemp) / 2;
      sensi = (5 * dtemp * dtemp) / 8;
      if (temp < VLOW_BAND_EDGE) begin
        e     = temp - VLOW_BAND_EDGE;
        offi  = offi + 7 * e * e;
        sensi = sensi + 4 * e * e;
      end
    end else begin
      ti    = trunc_shift(2 * dt * dt, 37);
      offi  = (dtemp * dtemp) / 16;
      sensi = 0;
    end

    off  = off - offi;
    sens = sens - sensi;
    t    = temp - ti;
    p    = trunc_shift(trunc_shift(d1 * sens, 21) - off, 13);

    r.clipped = 1'b0;
    if (p < 0) begin
      p = 0;
      r.clipped = 1'b1;
    end
    if (p > P_MAX) begin
      p = P_MAX;
      r.clipped = 1'b1;
    end
    if (t < T_MIN) begin
      t = T_MIN;
      r.clipped = 1'b1;
    end
    if (t > T_MAX) begin
      t = T_MAX;
      r.clipped = 1'b1;
    end
    r.pressure    = p[PRES_W-1:0];
    r.temperature = t[TOUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t              want;
    reg_idx_e          slot;
    logic [COEF_W-1:0] word;
    logic              known;
    if (!rst_ni) begin
      cal = '0;
      expected_readings.delete();
    end else begin
      // calibration port: track writes, check reads
      if (psel_i && penable_i && pready_i) begin
        slot  = reg_idx_e'(paddr_i[PADDR_W-1:2]);
        known = 1'b1;
        word  = '0;
        case (slot)
          REG_SENS:        word = cal.sens;
          REG_OFFSET:      word = cal.offset;
          REG_SENS_TEMP:   word = cal.sens_temp;
          REG_OFFSET_TEMP: word = cal.offset_temp;
          REG_REF_TEMP:    word = cal.ref_temp;
          REG_TEMP_SLOPE:  word = cal.temp_slope;
          default:         known = 1'b0;
        endcase
        if (pwrite_i) begin
          case (slot)
            REG_SENS:        cal.sens        = pwdata_i[COEF_W-1:0];
            REG_OFFSET:      cal.offset      = pwdata_i[COEF_W-1:0];
            REG_SENS_TEMP:   cal.sens_temp   = pwdata_i[COEF_W-1:0];
            REG_OFFSET_TEMP: cal.offset_temp = pwdata_i[COEF_W-1:0];
            REG_REF_TEMP:    cal.ref_temp    = pwdata_i[COEF_W-1:0];
            REG_TEMP_SLOPE:  cal.temp_slope  = pwdata_i[COEF_W-1:0];
            default: ;
          endcase
        end else if (known && prdata_i[COEF_W-1:0] != word) begin
          $error("prdata at 0x%0h: expected %0d, got %0d", paddr_i, word,
                 prdata_i[COEF_W-1:0]);
          mismatch_cnt++;
        end
      end

      if (push_i && !full_i)
        expected_readings.push_back(compensate(raw_pressure_i, raw_temperature_i));

      if (pop_i && !empty_i) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected item: pressure_out %0d, temperature_out %0d, clipped %0b",
                 pressure_out_i, temperature_out_i, clipped_i);
          mismatch_cnt++;
        end else begin
          want = expected_readings.pop_front();
          checked_cnt++;
          if (want.clipped) saturated_cnt++;
          if (pressure_out_i != want.pressure) begin
            $error("pressure_out: expected %0d, got %0d", want.pressure, pressure_out_i);
            mismatch_cnt++;
          end
          if (temperature_out_i != want.temperature) begin
            $error("temperature_out: expected %0d, got %0d", want.temperature,
                   temperature_out_i);
            mismatch_cnt++;
          end
          if (clipped_i != want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, clipped_i);
            mismatch_cnt++;
          end
        end
      end
    end
    pending_o    <= expected_readings.size();
    mismatches_o <= mismatch_cnt;
    checked_o    <= checked_cnt;
    saturated_o  <= saturated_cnt;
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  // Run shape: random phases of conversion pairs, each under its own calibration set
  localparam int PHASES            = 6;
  localparam int SAMPLES_PER_PHASE = 238;
  localparam int CYCLE_LIMIT       = 300_000;
  // Room for a result to pass the front, queue and back stages, plus margin
  localparam int SETTLE_CYCLES     = 20;
  // Register slots that decode to nothing
  localparam int UNUSED_SLOT_A     = 6;
  localparam int UNUSED_SLOT_B     = 7;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  // Typical factory calibration of this sensor family
  localparam cfg_t DATASHEET_CAL = '{sens: 16'd40127, offset: 16'd36924,
                                     sens_temp: 16'd23317, offset_temp: 16'd23282,
                                     ref_temp: 16'd33464, temp_slope: 16'd28312};

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     push            = 1'b0;
  logic [RAW_W-1:0]         raw_pressure    = '0;
  logic [RAW_W-1:0]         raw_temperature = '0;
  logic                     pop             = 1'b0;
  logic                     psel            = 1'b0;
  logic                     penable         = 1'b0;
  logic                     pwrite          = 1'b0;
  logic [PADDR_W-1:0]       paddr           = '0;
  logic [PDATA_W-1:0]       pwdata          = '0;
  logic                     full;
  logic                     empty;
  logic [PRES_W-1:0]        pressure_out;
  logic signed [TOUT_W-1:0] temperature_out;
  logic                     clipped;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  int   pending, mismatches, checked, saturated;
  cfg_t cal_now;
  int   gap_pct    = 0;
  int   stall_pct  = 0;
  int   stall_left = 0;
  int   sent       = 0;
  // the reset calibration (all zero) counts as the first set
  int   cal_sets   = 1;

  always #2 clk = ~clk;

  pressure_temp_compensation_unit DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push              (push),
    .full              (full),
    .raw_pressure_i    (raw_pressure),
    .raw_temperature_i (raw_temperature),
    .empty             (empty),
    .pop               (pop),
    .pressure_out_o    (pressure_out),
    .temperature_out_o (temperature_out),
    .clipped_o         (clipped),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  compensation_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push_i            (push),
    .full_i            (full),
    .raw_pressure_i    (raw_pressure),
    .raw_temperature_i (raw_temperature),
    .empty_i           (empty),
    .pop_i             (pop),
    .pressure_out_i    (pressure_out),
    .temperature_out_i (temperature_out),
    .clipped_i         (clipped),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .pready_i          (pready),
    .pending_o         (pending),
    .mismatches_o      (mismatches),
    .checked_o         (checked),
    .saturated_o       (saturated)
  );

  // Result side: hold pop low in random bursts, otherwise keep draining.
  // stall_pct of zero gives a stretch with no back-pressure at all.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pop        <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 9);
      pop        <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // One register transfer: setup cycle, access cycle until pready, then a return to
  // idle so the next transfer starts in a fresh time step.
  task automatic reg_access(input logic wr, input int slot, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(slot * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full calibration set. Junk in the upper half of the bus word must be
  // masked off; writes to the unused slots must change nothing, which the read-back
  // of the six real registers confirms.
  task automatic load_cal(input cfg_t c);
    reg_access(1'b1, REG_SENS,        {16'($urandom), c.sens});
    reg_access(1'b1, REG_OFFSET,      {16'($urandom), c.offset});
    reg_access(1'b1, REG_SENS_TEMP,   {16'($urandom), c.sens_temp});
    reg_access(1'b1, REG_OFFSET_TEMP, {16'($urandom), c.offset_temp});
    reg_access(1'b1, REG_REF_TEMP,    {16'($urandom), c.ref_temp});
    reg_access(1'b1, REG_TEMP_SLOPE,  {16'($urandom), c.temp_slope});
    reg_access(1'b1, UNUSED_SLOT_A, $urandom);
    reg_access(1'b1, UNUSED_SLOT_B, $urandom);
    for (int s = REG_SENS; s <= REG_TEMP_SLOPE; s++)
      reg_access(1'b0, s, '0);
    cal_now = c;
    cal_sets++;
  endtask

  // Offer one conversion pair, maybe after an idle burst. push stays high on return
  // so back-to-back items need no second assignment in the same step.
  task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int n;
    if ($urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 10);
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    push            <= 1'b1;
    raw_pressure    <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (full);
    sent++;
  endtask

  // Drop push and hold off until every expected result is back
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Nudge a typical word by a few thousand, or now and then replace it outright
  function automatic logic [COEF_W-1:0] jitter(input logic [COEF_W-1:0] base);
    if ($urandom_range(0, 2) == 0) return COEF_W'($urandom);
    return COEF_W'(int'(base) + int'($urandom_range(0, 6000)) - 3000);
  endfunction

  // Hard stop if anything hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("run timed out with %0d results still expected", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cfg_t c;
    int   kind, d2i;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct   = 25;
    stall_pct = 25;

    // Zero calibration straight out of reset: everything collapses onto the
    // high band with no sensitivity, so pressure pins at zero.
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(24'd9085466, 24'd8569150);
    drain();

    // Datasheet calibration: band edges and both clamps.
    load_cal(DATASHEET_CAL);
    send_sample(24'd9085466, 24'd8569150);   // typical room reading
    send_sample('0, 24'd8569150);            // pressure clamps at zero
    send_sample(RAW_MAX, 24'd8569150);       // pressure clamps at full scale
    send_sample(24'd9085466, '0);            // far below the cold limit
    send_sample(24'd9085466, RAW_MAX);       // far above the hot limit
    send_sample(24'd9085466, 24'd8566784);   // zero temperature delta
    send_sample(24'd9085466, 24'd8566488);   // first-order 20.00 degC, high band
    send_sample(24'd9085466, 24'd8566487);   // just into the low band
    send_sample(24'd9085466, 24'd7529468);   // -15.00 degC, still low band
    send_sample(24'd9085466, 24'd7529467);   // just into the very low band
    send_sample(24'd9085466, 24'd10000000);  // warm, well inside range
    send_sample(24'hAAAAAA, 24'h555555);
    send_sample(24'h555555, 24'hAAAAAA);
    drain();

    // All-ones calibration: widest products in the datapath.
    load_cal('1);
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(RAW_MAX, '0);
    send_sample('0, RAW_MAX);
    send_sample(24'hAAAAAA, 24'h555555);
    drain();

    // Random phases. Most pairs sit around the reference temperature so the
    // bands get spread; the rest are raw noise over the full field range.
    for (int ph = 0; ph < PHASES; ph++) begin
      c.sens        = jitter(DATASHEET_CAL.sens);
      c.offset      = jitter(DATASHEET_CAL.offset);
      c.sens_temp   = jitter(DATASHEET_CAL.sens_temp);
      c.offset_temp = jitter(DATASHEET_CAL.offset_temp);
      c.ref_temp    = jitter(DATASHEET_CAL.ref_temp);
      c.temp_slope  = jitter(DATASHEET_CAL.temp_slope);
      load_cal(c);
      // last phase runs flat out on both sides
      if (ph == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 40);
        stall_pct = $urandom_range(0, 40);
      end
      repeat (SAMPLES_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          send_sample(RAW_W'($urandom), RAW_W'($urandom));
        end else begin
          d2i = int'(cal_now.ref_temp) * 256 + int'($urandom_range(0, 4_800_000))
                - 2_400_000;
          if (d2i < 0) d2i = 0;
          if (d2i > int'(RAW_MAX)) d2i = int'(RAW_MAX);
          send_sample(RAW_W'($urandom_range(6_000_000, 12_000_000)), RAW_W'(d2i));
        end
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d conversion pairs under %0d calibration sets (%0d of them random).",
             sent, cal_sets, PHASES);
    $display("Compared %0d results, %0d of them saturated.", checked, saturated);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ptc_pkg.sv
sv/ptc_cfg.sv
sv/ptc_front.sv
sv/ptc_queue.sv
sv/ptc_back.sv
sv/pressure_temp_compensation_unit.sv
test/compensation_checker.sv
test/tb.sv
